@@ hdl/jet_pkg.sv @@
// Shared types and constants for the Julia escape-time block.
// No dependencies; imported by jet_ctrl, jet_datapath and julia_escape_time.
package jet_pkg;

  localparam int IN_W        = 32;   // start_re / start_im width
  localparam int OUT_COUNT_W = 16;   // escape_count width
  localparam int Z_W         = 64;   // iterate width
  localparam int HALF_W      = 32;   // multiplier operand width
  localparam int ACC_W       = 128;  // exact square / product width
  localparam int PH_W        = 2;    // partial-product phase counter
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int MAX_ITER_RESET = 100;

  localparam logic [CFG_INDEX_W-1:0] REG_JULIA_PRESET   = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITERATIONS = 4'd1;

  localparam logic [PH_W-1:0] PH_LAST = 2'd3;

  typedef struct packed {
    logic signed [IN_W-1:0] start_re;
    logic signed [IN_W-1:0] start_im;
  } in_word_t;

  typedef struct packed {
    logic [OUT_COUNT_W-1:0] escape_count;
    logic                   stayed_bounded;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic            load;
    logic            mag_en;
    logic            mul_en;
    logic [PH_W-1:0] mul_phase;
    logic            cmb1_en;
    logic            cmb2_en;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pre_esc;
    logic escaped;
  } dp_sts_t;

endpackage

@@ hdl/jet_datapath.sv @@
// Datapath: z registers, three 32x32 multipliers with 128-bit accumulators,
// escape compare and the z*z + c update. Depends on jet_pkg.
module jet_datapath #(
  parameter int FRAC_BITS = 28
) (
  input  logic              clk,
  input  logic              rst_n,
  input  jet_pkg::dp_cmd_t  cmd,
  output jet_pkg::dp_sts_t  sts,
  input  logic              preset,
  input  jet_pkg::in_word_t start
);
  import jet_pkg::*;

  localparam logic [Z_W-1:0] C_RE0 = ((64'd2 << FRAC_BITS) + 64'd2) / 64'd5;
  localparam logic [Z_W-1:0] C_IM0 = 64'd0 - (((64'd13 << FRAC_BITS) + 64'd20) / 64'd40);
  localparam logic [Z_W-1:0] C_RE1 = 64'd0 - (((64'd4 << FRAC_BITS) + 64'd2) / 64'd5);
  localparam logic [Z_W-1:0] C_IM1 = ((64'd39 << FRAC_BITS) + 64'd125) / 64'd250;
  localparam logic [Z_W-1:0]   LIM    = 64'd2 << FRAC_BITS;
  localparam logic [ACC_W-1:0] THRESH = 128'd1 << (2 * FRAC_BITS + 2);

  logic [Z_W-1:0]    x_r, y_r, ax_r, ay_r;
  logic [Z_W-1:0]    ax, ay, cre, cim;
  logic              sgn_r;
  logic [HALF_W-1:0] op_xa, op_xb, op_ya, op_yb;
  logic [Z_W-1:0]    pp_xx, pp_yy, pp_xy;
  logic [Z_W-1:0]    pp_xx_r, pp_yy_r, pp_xy_r;
  logic              acc_en_r;
  logic [PH_W-1:0]   acc_ph_r;
  logic [ACC_W-1:0]  acc_xx_r, acc_yy_r, acc_xy_r;
  logic [ACC_W-1:0]  sum_sq;
  logic [ACC_W-1:0]  diff_r, prod_r;
  logic              esc_r;

  // partial product placed at its weight: lo*lo, lo*hi, hi*lo, hi*hi
  function automatic logic [ACC_W-1:0] place(input logic [Z_W-1:0] pp,
                                             input logic [PH_W-1:0] ph);
    logic [ACC_W-1:0] v;
    case (ph)
      2'd0:    v = {64'd0, pp};
      PH_LAST: v = {pp, 64'd0};
      default: v = {32'd0, pp, 32'd0};
    endcase
    return v;
  endfunction

  assign ax = x_r[Z_W-1] ? (~x_r + 64'd1) : x_r;
  assign ay = y_r[Z_W-1] ? (~y_r + 64'd1) : y_r;
  assign sts.pre_esc = (ax > LIM) || (ay > LIM);
  assign sts.escaped = esc_r;

  assign op_xa = cmd.mul_phase[1] ? ax_r[Z_W-1:HALF_W] : ax_r[HALF_W-1:0];
  assign op_xb = cmd.mul_phase[0] ? ax_r[Z_W-1:HALF_W] : ax_r[HALF_W-1:0];
  assign op_ya = cmd.mul_phase[1] ? ay_r[Z_W-1:HALF_W] : ay_r[HALF_W-1:0];
  assign op_yb = cmd.mul_phase[0] ? ay_r[Z_W-1:HALF_W] : ay_r[HALF_W-1:0];

  assign pp_xx = {32'd0, op_xa} * {32'd0, op_xb};
  assign pp_yy = {32'd0, op_ya} * {32'd0, op_yb};
  assign pp_xy = {32'd0, op_xa} * {32'd0, op_yb};

  assign sum_sq = acc_xx_r + acc_yy_r;
  assign cre = preset ? C_RE1 : C_RE0;
  assign cim = preset ? C_IM1 : C_IM0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    acc_ph_r <= cmd.mul_phase;
    if (cmd.load) begin
      x_r <= {{(Z_W-IN_W){start.start_re[IN_W-1]}}, start.start_re};
      y_r <= {{(Z_W-IN_W){start.start_im[IN_W-1]}}, start.start_im};
    end else if (cmd.cmb2_en) begin
      x_r <= diff_r[FRAC_BITS+Z_W-1:FRAC_BITS] + cre;
      y_r <= prod_r[FRAC_BITS+Z_W-2:FRAC_BITS-1] + cim;
    end
    if (cmd.mag_en) begin
      ax_r  <= ax;
      ay_r  <= ay;
      sgn_r <= x_r[Z_W-1] ^ y_r[Z_W-1];
    end
    if (cmd.mul_en) begin
      pp_xx_r <= pp_xx;
      pp_yy_r <= pp_yy;
      pp_xy_r <= pp_xy;
    end
    if (cmd.mag_en) begin
      acc_xx_r <= '0;
      acc_yy_r <= '0;
      acc_xy_r <= '0;
    end else if (acc_en_r) begin
      acc_xx_r <= acc_xx_r + place(pp_xx_r, acc_ph_r);
      acc_yy_r <= acc_yy_r + place(pp_yy_r, acc_ph_r);
      acc_xy_r <= acc_xy_r + place(pp_xy_r, acc_ph_r);
    end
    if (cmd.cmb1_en) begin
      esc_r  <= sum_sq > THRESH;
      diff_r <= acc_xx_r - acc_yy_r;
      prod_r <= sgn_r ? (~acc_xy_r + 128'd1) : acc_xy_r;
    end
  end

endmodule

@@ hdl/jet_ctrl.sv @@
// Controller: handshakes, iteration sequencing, iteration counter and the
// output register. Depends on jet_pkg; drives jet_datapath through dp_cmd_t.
module jet_ctrl #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  output jet_pkg::out_word_t     out_data,
  input  logic [COUNT_WIDTH-1:0] max_iter,
  output jet_pkg::dp_cmd_t       cmd,
  input  jet_pkg::dp_sts_t       sts
);
  import jet_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAG  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_CMB1 = 3'd4;
  localparam logic [2:0] S_CMB2 = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]             state_r, state_nxt;
  logic [PH_W-1:0]        phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] iter_r, iter_nxt, iter_inc;
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_data_r, out_data_nxt;

  assign iter_inc  = iter_r + COUNT_WIDTH'(1);
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    iter_nxt      = iter_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          iter_nxt  = '0;
          state_nxt = (max_iter == '0) ? S_DONE : S_MAG;
        end
      end
      S_MAG: begin
        cmd.mag_en = 1'b1;
        phase_nxt  = '0;
        state_nxt  = sts.pre_esc ? S_DONE : S_MUL;
      end
      S_MUL: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = phase_r;
        phase_nxt     = phase_r + PH_W'(1);
        if (phase_r == PH_LAST) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        // last partial product lands in the accumulators
        state_nxt = S_CMB1;
      end
      S_CMB1: begin
        cmd.cmb1_en = 1'b1;
        state_nxt   = S_CMB2;
      end
      S_CMB2: begin
        if (sts.escaped) begin
          state_nxt = S_DONE;
        end else begin
          cmd.cmb2_en = 1'b1;
          iter_nxt    = iter_inc;
          state_nxt   = (iter_inc == max_iter) ? S_DONE : S_MAG;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.escape_count   = OUT_COUNT_W'(iter_r);
          out_data_nxt.stayed_bounded = (iter_r == max_iter);
          state_nxt                   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= '0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

@@ hdl/julia_escape_time.sv @@
// Top level of the Julia escape-time block: configuration registers,
// controller and datapath. Depends on jet_pkg, jet_ctrl and jet_datapath.
//
//   channel   handshake            word
//   in_       in_valid / in_stall    in_word_t  {start_re, start_im}
//   out_      out_valid / out_stall  out_word_t {escape_count, stayed_bounded}
//   cfg_      cfg_valid / cfg_ready  cfg_index, cfg_data (0: preset, 1: max)
//
// One word at a time. Each iteration steps through magnitudes, four
// partial products on three 32x32 multipliers, accumulate, escape
// compare and z update.
// A finished result sits in the output register; the next word is taken
// while it waits. Synchronous active-low reset; no clearing pass.
module julia_escape_time #(
  parameter int FRAC_BITS   = 28,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  jet_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output jet_pkg::out_word_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [jet_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [jet_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import jet_pkg::*;

  logic                   preset_r;
  logic [COUNT_WIDTH-1:0] max_iter_r;
  dp_cmd_t                cmd;
  dp_sts_t                sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preset_r   <= 1'b0;
      max_iter_r <= COUNT_WIDTH'(MAX_ITER_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_JULIA_PRESET:   preset_r   <= cfg_data[0];
        REG_MAX_ITERATIONS: max_iter_r <= cfg_data[COUNT_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  jet_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .max_iter  (max_iter_r),
    .cmd       (cmd),
    .sts       (sts)
  );

  jet_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .preset (preset_r),
    .start  (in_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block not busy after taking a word");

  a_bounded_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.stayed_bounded) |->
      (out_data.escape_count == OUT_COUNT_W'(max_iter_r)))
    else $error("bounded result with count other than the limit");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word appeared without work in progress");

endmodule

@@ bench/julia_escape_time_tb.sv @@
// Testbench for julia_escape_time: directed and random pixels checked against a
// local escape-time predictor, with random idling on both stream sides.
// Depends on jet_pkg and the julia_escape_time RTL.
module julia_escape_time_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jet_pkg::*;

  localparam int FRAC  = 28;
  localparam int CNT_W = 16;
  localparam logic signed [63:0]  TWO_FIX = 64'sd2 <<< FRAC;
  localparam logic signed [127:0] FOUR_SQ = 128'sd4 <<< (2 * FRAC);

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_word_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_word_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // shadow of the block's registers
  bit          cur_preset = 1'b0;
  logic [15:0] cur_limit  = 16'(MAX_ITER_RESET);

  out_word_t expected_counts[$];
  int        errors     = 0;
  int        n_points   = 0;
  int        n_writes   = 0;
  bit        src_calm   = 1'b0;
  bit        sink_calm  = 1'b0;

  julia_escape_time #(
    .FRAC_BITS   (FRAC),
    .COUNT_WIDTH (CNT_W)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // |c| * 2^FRAC rounded to nearest, then signed
  function automatic logic signed [63:0] fixed_const(longint unsigned num,
                                                     longint unsigned den, bit neg);
    longint unsigned m;
    m = ((num << FRAC) + den / 2) / den;
    return neg ? -m : m;
  endfunction

  function automatic out_word_t julia_count(in_word_t w, bit preset, logic [15:0] limit);
    logic signed [63:0]  zr, zi, cr, ci;
    logic signed [127:0] wr, wi, shifted;
    int unsigned         n;
    out_word_t           res;
    if (preset) begin
      cr = fixed_const(4, 5, 1'b1);
      ci = fixed_const(39, 250, 1'b0);
    end else begin
      cr = fixed_const(2, 5, 1'b0);
      ci = fixed_const(13, 40, 1'b1);
    end
    zr = {{32{w.start_re[31]}}, w.start_re};
    zi = {{32{w.start_im[31]}}, w.start_im};
    n = 0;
    while (n < limit) begin
      if (zr > TWO_FIX || zr < -TWO_FIX || zi > TWO_FIX || zi < -TWO_FIX) break;
      wr = zr;
      wi = zi;
      if (wr * wr + wi * wi > FOUR_SQ) break;
      shifted = (wr * wr - wi * wi) >>> FRAC;
      zr = shifted[63:0] + cr;
      // 2xy: one fraction bit less of shift
      shifted = (wr * wi) >>> (FRAC - 1);
      zi = shifted[63:0] + ci;
      n++;
    end
    res.escape_count   = 16'(n);
    res.stayed_bounded = (n == limit);
    return res;
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // entered and left at a rising edge; caller lowers in_valid when done
  task automatic send_point(logic [31:0] re, logic [31:0] im);
    in_word_t w;
    int       gap;
    w.start_re = re;
    w.start_im = im;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    expected_counts.push_back(julia_count(w, cur_preset, cur_limit));
    n_points++;
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_JULIA_PRESET) cur_preset = val[0];
    else if (idx == REG_MAX_ITERATIONS) cur_limit = val[15:0];
    n_writes++;
    @(posedge clk);
  endtask

  // sink side stall pattern
  initial begin : sink_stall
    int left;
    int r;
    bit level;
    left  = 0;
    level = 1'b0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          level = 1'b0;
          left  = $urandom_range(1, 8);
        end else if (r < 92) begin
          level = 1'b1;
          left  = $urandom_range(1, 3);
        end else begin
          level = 1'b1;
          left  = $urandom_range(10, 40);
        end
      end
      left--;
      out_stall <= sink_calm ? 1'b0 : level;
    end
  end

  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_counts.size() == 0) begin
        $display("%0t unexpected word: count %0d bounded %0d", $realtime,
                 out_data.escape_count, out_data.stayed_bounded);
        errors++;
      end else begin
        want = expected_counts.pop_front();
        if (out_data.escape_count !== want.escape_count) begin
          $display("%0t escape_count expected %0d got %0d", $realtime,
                   want.escape_count, out_data.escape_count);
          errors++;
        end
        if (out_data.stayed_bounded !== want.stayed_bounded) begin
          $display("%0t stayed_bounded expected %0d got %0d", $realtime,
                   want.stayed_bounded, out_data.stayed_bounded);
          errors++;
        end
      end
    end
  end

  // registers untouched: preset 0, limit 100
  task automatic test_reset_defaults();
    send_point(32'h0000_0000, 32'h0000_0000);
    send_point(32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h8000_0000);
    wait_results();
  endtask

  // |z|^2 exactly 4 must not count as escaped; one lsb past it must
  task automatic test_escape_boundary();
    write_reg(REG_JULIA_PRESET, 32'd1);
    write_reg(REG_MAX_ITERATIONS, 32'd20);
    send_point(32'h2000_0000, 32'h0000_0000);
    send_point(32'he000_0000, 32'h0000_0000);
    send_point(32'h0000_0000, 32'h2000_0000);
    send_point(32'h0000_0000, 32'he000_0000);
    send_point(32'h2000_0000, 32'h0000_0001);
    send_point(32'h2000_0001, 32'h0000_0000);
    send_point(32'h16a0_9e66, 32'he95f_619a);
    wait_results();
  endtask

  // no test at all with a zero limit, even far outside the circle
  task automatic test_zero_limit();
    write_reg(REG_MAX_ITERATIONS, 32'd0);
    send_point(32'h0000_0000, 32'h0000_0000);
    send_point(32'h7fff_ffff, 32'h0000_0000);
    send_point(32'h8000_0000, 32'h8000_0000);
    wait_results();
  endtask

  // only low bits kept; indexes past the limit register are dropped
  task automatic test_register_masking();
    write_reg(REG_JULIA_PRESET, 32'hffff_fffe);
    write_reg(REG_MAX_ITERATIONS, 32'hffff_0003);
    write_reg(CFG_INDEX_W'(2), 32'hffff_ffff);
    write_reg({CFG_INDEX_W{1'b1}}, 32'h0000_0000);
    send_point(32'h0000_0000, 32'h0000_0000);
    send_point(32'h0100_0000, 32'hff00_0000);
    wait_results();
  endtask

  // largest limit; only points that leave fast, so runtime stays short
  task automatic test_long_limit();
    write_reg(REG_JULIA_PRESET, 32'h0000_0003);
    write_reg(REG_MAX_ITERATIONS, 32'h0000_ffff);
    send_point(32'h1e00_0000, 32'h0000_0000);
    send_point(32'he000_0000, 32'h1d00_0000);
    send_point(32'h7fff_ffff, 32'h0000_0000);
    send_point(32'h0000_0000, 32'hc000_0000);
    wait_results();
  endtask

  task automatic test_random_points();
    logic [31:0] re, im;
    logic [15:0] lim;
    int          r;
    for (int phase = 0; phase < 20; phase++) begin
      wait_results();
      case ($urandom_range(0, 9))
        0:       lim = 16'd0;
        1:       lim = 16'd1;
        2:       lim = 16'd255;
        3:       lim = 16'd100;
        default: lim = 16'($urandom_range(2, 48));
      endcase
      write_reg(REG_JULIA_PRESET, {$urandom} );
      write_reg(REG_MAX_ITERATIONS, {16'($urandom), lim});
      src_calm  = (phase % 4 == 0);
      sink_calm = (phase % 4 == 0) || (phase % 7 == 3);
      for (int k = 0; k < 25; k++) begin
        r = $urandom_range(0, 9);
        if (r < 6) begin
          re = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
          im = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
        end else if (r < 8) begin
          re = $urandom_range(0, 32'h1800_0000) - 32'h0c00_0000;
          im = $urandom_range(0, 32'h1800_0000) - 32'h0c00_0000;
        end else begin
          re = $urandom;
          im = $urandom;
        end
        send_point(re, im);
      end
    end
    src_calm  = 1'b0;
    sink_calm = 1'b0;
    wait_results();
  endtask

  initial begin : run
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_escape_boundary();
    test_zero_limit();
    test_register_masking();
    test_long_limit();
    test_random_points();
    repeat (40) @(posedge clk);
    $display("covered %0d pixels over %0d register writes,", n_points, n_writes);
    $display("both presets, limits from 0 to 65535, exact escape boundary");
    if (errors == 0 && expected_counts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
